/* rtl/core/mmgray_pkg.sv */
// Shared types and constants for the min/max gray normalizer.
// No dependencies; imported by mmgray_div and minmax_normalize_to_gray_unit.
package mmgray_pkg;

   localparam int GRID_CELLS_DEF  = 4096;
   localparam int SAMPLE_BITS_DEF = 32;
   localparam int CSR_BITS        = 13;
   localparam logic [CSR_BITS-1:0] CSR_RESET = 13'd4096;
   localparam int GRAY_BITS       = 8;
   localparam int STEP_BITS       = $clog2(GRAY_BITS);

   typedef logic [GRAY_BITS-1:0] gray_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EMIT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_PREP,
      ST_DIV
   } state_type;

endpackage

/* rtl/core/minmax_normalize_to_gray_unit.sv */
// Min/max contrast stretch of a square field of signed samples to 8-bit gray.
// Depends on mmgray_pkg and mmgray_div.
//
// A load request (req_op = 0) writes one sample into the frame store and updates the
// running minimum and maximum in the cycle it is accepted; busy stays low, so a new
// request can follow in the next cycle. Once csr cells_in_use samples are in, each
// emit request (req_op = 1) returns one gray pixel, floor((s-min)*255/(max-min)),
// with rsp_last_pixel on the final pixel of the frame, which also rearms the block
// for the next frame. An emit keeps busy high, and no new request is taken, through
// its steps: a store read, a clamp of the offset, forming 255 times the offset, then
// eight restoring division steps (one quotient bit a cycle) and a report. The
// result shows on rsp_gray/rsp_last_pixel for exactly one cycle with rsp_strobe and
// cannot be held off. Loads while the frame is full and emits before it is full are
// dropped with no response. The frame store has no reset and needs no clearing pass.
// cells_in_use of 0 acts as 1 and values above GRID_CELLS act as GRID_CELLS; write it
// only while the block is idle. A flat range (max equal to min) returns 0.
module minmax_normalize_to_gray_unit #(
   parameter int GRID_CELLS  = mmgray_pkg::GRID_CELLS_DEF,
   parameter int SAMPLE_BITS = mmgray_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_op,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample,
   output logic                               rsp_strobe,
   output mmgray_pkg::gray_type               rsp_gray,
   output logic                               rsp_last_pixel,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mmgray_pkg::CSR_BITS-1:0]    csr_data
);
   import mmgray_pkg::*;

   localparam int ADDR_W = $clog2(GRID_CELLS);
   localparam int CNT_W  = $clog2(GRID_CELLS + 1);
   localparam int CMP_W  = (CNT_W > CSR_BITS) ? CNT_W : CSR_BITS;
   localparam int NUM_W  = SAMPLE_BITS + GRAY_BITS;
   localparam logic [CMP_W-1:0] GRID_LIMIT = CMP_W'(GRID_CELLS);
   localparam logic signed [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // control state
   state_type               state_ff;
   state_type               state_in;
   logic [CSR_BITS-1:0]     cells_ff;
   logic [CNT_W-1:0]        load_count_ff;
   logic [ADDR_W-1:0]       rd_ptr_ff;
   logic                    frame_full_ff;
   logic                    rsp_strobe_ff;

   // datapath
   logic signed [SAMPLE_BITS-1:0] min_ff;
   logic signed [SAMPLE_BITS-1:0] max_ff;
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic [SAMPLE_BITS-1:0]        range_ff;
   logic [SAMPLE_BITS-1:0]        offset_ff;
   logic [SAMPLE_BITS-1:0]        offset_in;
   logic                          flat_ff;
   logic                          last_ff;
   gray_type                      gray_ff;
   logic                          last_pixel_ff;

   logic signed [SAMPLE_BITS-1:0] frame_mem [GRID_CELLS];

   logic              accept;
   logic              do_load;
   logic              do_emit;
   logic [CMP_W-1:0]  eff_cells;
   logic [NUM_W-1:0]  scaled;
   logic              div_start;
   logic              div_done;
   gray_type          div_quo;

   assign accept  = start && !busy;
   assign do_load = accept && (req_op == OP_LOAD) && !frame_full_ff;
   assign do_emit = accept && (req_op == OP_EMIT) && frame_full_ff;

   // clamp the configured cell count into 1..GRID_CELLS
   always_comb begin
      if (cells_ff == '0) begin
         eff_cells = CMP_W'(1);
      end else if (CMP_W'(cells_ff) > GRID_LIMIT) begin
         eff_cells = GRID_LIMIT;
      end else begin
         eff_cells = CMP_W'(cells_ff);
      end
   end

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff <= CSR_RESET;
      end else if (csr_valid && csr_ready) begin
         cells_ff <= csr_data;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (do_emit) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   // frame store: write on load, registered read on emit
   always_ff @(posedge clock) begin
      if (do_load) begin
         frame_mem[load_count_ff[ADDR_W-1:0]] <= req_sample;
      end
      if (do_emit) begin
         rd_data_ff <= frame_mem[rd_ptr_ff];
      end
   end

   // frame bookkeeping: counts, running extremes, full flag
   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         rd_ptr_ff     <= '0;
         frame_full_ff <= 1'b0;
         min_ff        <= MOST_POS;
         max_ff        <= MOST_NEG;
      end else if (do_load) begin
         load_count_ff <= load_count_ff + 1'b1;
         if (req_sample < min_ff) begin
            min_ff <= req_sample;
         end
         if (req_sample > max_ff) begin
            max_ff <= req_sample;
         end
         if ((CMP_W'(load_count_ff) + CMP_W'(1)) >= eff_cells) begin
            frame_full_ff <= 1'b1;
         end
      end else if (div_done) begin
         if (last_ff) begin
            // rearm for the next frame
            load_count_ff <= '0;
            rd_ptr_ff     <= '0;
            frame_full_ff <= 1'b0;
            min_ff        <= MOST_POS;
            max_ff        <= MOST_NEG;
         end else begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // capture range, flat flag and last mark when the emit is taken
   always_ff @(posedge clock) begin
      if (do_emit) begin
         range_ff <= SAMPLE_BITS'(max_ff - min_ff);
         flat_ff  <= (max_ff == min_ff);
         last_ff  <= (CMP_W'(rd_ptr_ff) + CMP_W'(1)) >= eff_cells;
      end
   end

   // clamp the sample offset into 0..range; stale entries may lie outside
   always_comb begin
      if (rd_data_ff <= min_ff) begin
         offset_in = '0;
      end else if (rd_data_ff >= max_ff) begin
         offset_in = range_ff;
      end else begin
         offset_in = SAMPLE_BITS'(rd_data_ff - min_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         offset_ff <= offset_in;
      end
   end

   // 255 * offset as 256 * offset - offset
   assign scaled = {offset_ff, {GRAY_BITS{1'b0}}} - {{GRAY_BITS{1'b0}}, offset_ff};

   mmgray_div #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (scaled),
      .divisor  (range_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // response register: one-cycle strobe, no back pressure
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= div_done;
      end
   end

   always_ff @(posedge clock) begin
      if (div_done) begin
         gray_ff       <= flat_ff ? '0 : div_quo;
         last_pixel_ff <= last_ff;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_gray       = gray_ff;
   assign rsp_last_pixel = last_pixel_ff;

`ifndef ASSERT_OFF
   a_rsp_after_div: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_DIV))
      else $error("response without a finished division");

   a_busy_needs_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> frame_full_ff)
      else $error("emit in progress on a frame that is not full");

   a_flat_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && flat_ff) |-> (gray_ff == '0))
      else $error("flat range produced a nonzero pixel");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(load_count_ff) <= GRID_LIMIT)
      else $error("load count ran past the frame store");

   a_last_rearms: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && last_pixel_ff) |-> !frame_full_ff)
      else $error("frame still full after its last pixel");
`endif

endmodule

/* rtl/core/mmgray_div.sv */
// Restoring divider, one quotient bit per cycle, for an 8-bit quotient.
// Depends on mmgray_pkg. Dividend must be below 256 times the divisor.
module mmgray_div #(
   parameter int SAMPLE_BITS = mmgray_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   input  logic [SAMPLE_BITS+mmgray_pkg::GRAY_BITS-1:0]  dividend,
   input  logic [SAMPLE_BITS-1:0]                        divisor,
   output logic                                          done,
   output mmgray_pkg::gray_type                          quotient
);
   import mmgray_pkg::*;

   localparam int NUM_W = SAMPLE_BITS + GRAY_BITS;
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(GRAY_BITS - 1);

   logic [SAMPLE_BITS-1:0] rem_ff;
   logic [SAMPLE_BITS-1:0] rem_in;
   logic [GRAY_BITS-1:0]   low_ff;
   gray_type               quo_ff;
   logic [STEP_BITS-1:0]   step_ff;
   logic                   run_ff;
   logic                   done_ff;
   logic [SAMPLE_BITS:0]   trial;
   logic                   fits;

   // shift the next dividend bit into the partial remainder and try the subtract
   assign trial  = {rem_ff, low_ff[GRAY_BITS-1]};
   assign fits   = trial >= {1'b0, divisor};
   assign rem_in = fits ? SAMPLE_BITS'(trial - {1'b0, divisor}) : trial[SAMPLE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= run_ff && (step_ff == LAST_STEP);
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[NUM_W-1:GRAY_BITS];
         low_ff <= dividend[GRAY_BITS-1:0];
      end else if (run_ff) begin
         rem_ff <= rem_in;
         low_ff <= {low_ff[GRAY_BITS-2:0], 1'b0};
         quo_ff <= {quo_ff[GRAY_BITS-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for minmax_normalize_to_gray_unit: a table of directed requests,
// then random frames, checked against pinned values or a gray predictor kept in this module.
// Depends on mmgray_pkg and the unit's RTL; reads no files.
module testbench;
   import mmgray_pkg::*;

   localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake before giving up
   localparam int SETTLE_TICKS = 16;    // wait after the owed pixels; longer than an emit, with some margin
   localparam int RANDOM_ITEMS = 1250;
   localparam int MAX_REPORTS  = 10;

   typedef enum logic [1:0] {
      ROW_LOAD,
      ROW_EMIT,
      ROW_CSR
   } row_kind_type;

   typedef enum logic [1:0] {
      SPREAD_WIDE,
      SPREAD_NARROW,
      SPREAD_FLAT,
      SPREAD_EDGES
   } spread_type;

   // One directed step; gray/last are used only where pinned is set.
   typedef struct packed {
      row_kind_type kind;
      logic [31:0]  value;
      logic         pinned;
      gray_type     gray;
      logic         last;
   } plan_row_type;

   typedef struct packed {
      gray_type gray;
      logic     last;
   } pixel_rec_type;

   localparam int PLAN_LEN = 25;
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      // after reset the frame is 4096 cells: an early emit is dropped
      '{ROW_EMIT, 32'h0000_0000, 1'b0, 8'd0,   1'b0},
      '{ROW_CSR,  32'd4,         1'b0, 8'd0,   1'b0},
      // full-scale frame: most negative, most positive, zero, 0x10000
      '{ROW_LOAD, 32'h8000_0000, 1'b0, 8'd0,   1'b0},
      '{ROW_LOAD, 32'h7FFF_FFFF, 1'b0, 8'd0,   1'b0},
      '{ROW_LOAD, 32'h0000_0000, 1'b0, 8'd0,   1'b0},
      '{ROW_LOAD, 32'h0001_0000, 1'b0, 8'd0,   1'b0},
      // load while full is ignored
      '{ROW_LOAD, 32'h0000_0005, 1'b0, 8'd0,   1'b0},
      '{ROW_EMIT, 32'hFFFF_FFFF, 1'b1, 8'd0,   1'b0},
      '{ROW_EMIT, 32'h0000_0000, 1'b1, 8'd255, 1'b0},
      '{ROW_EMIT, 32'h0000_0000, 1'b0, 8'd0,   1'b0},
      '{ROW_EMIT, 32'h0000_0000, 1'b0, 8'd0,   1'b0},
      // single-cell frame has a flat range
      '{ROW_CSR,  32'd1,         1'b0, 8'd0,   1'b0},
      '{ROW_LOAD, 32'h1234_5678, 1'b0, 8'd0,   1'b0},
      '{ROW_EMIT, 32'h0000_0000, 1'b1, 8'd0,   1'b1},
      // a cell count of zero acts as one
      '{ROW_CSR,  32'd0,         1'b0, 8'd0,   1'b0},
      '{ROW_LOAD, 32'hFFFF_FFF9, 1'b0, 8'd0,   1'b0},
      '{ROW_EMIT, 32'h0000_0000, 1'b1, 8'd0,   1'b1},
      // fill two cells, then widen to four: cells 2 and 3 still hold the
      // older frame's 0 and 0x10000, outside the new min/max
      '{ROW_CSR,  32'd2,         1'b0, 8'd0,   1'b0},
      '{ROW_LOAD, 32'd100,       1'b0, 8'd0,   1'b0},
      '{ROW_LOAD, 32'd200,       1'b0, 8'd0,   1'b0},
      '{ROW_CSR,  32'd4,         1'b0, 8'd0,   1'b0},
      '{ROW_EMIT, 32'h0000_0000, 1'b1, 8'd0,   1'b0},
      '{ROW_EMIT, 32'h0000_0000, 1'b1, 8'd255, 1'b0},
      '{ROW_EMIT, 32'h0000_0000, 1'b1, 8'd0,   1'b0},
      '{ROW_EMIT, 32'h0000_0000, 1'b1, 8'd255, 1'b1}
   };

   // DUT ports; every input starts at a known value
   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic                busy;
   logic                req_op         = OP_LOAD;
   logic signed [31:0]  req_sample     = '0;
   logic                rsp_strobe;
   gray_type            rsp_gray;
   logic                rsp_last_pixel;
   logic                csr_valid      = 1'b0;
   logic                csr_ready;
   logic [CSR_BITS-1:0] csr_data       = '0;

   // Shadow of the unit's frame state
   logic [31:0]         shadow_cells [GRID_CELLS_DEF];
   logic signed [31:0]  low_mark;
   logic signed [31:0]  high_mark;
   int                  cells_loaded;
   int                  read_slot;
   int                  max_loaded;     // cells 0..max_loaded-1 were written since reset
   bit                  frame_full;
   logic [CSR_BITS-1:0] cells_setting;

   pixel_rec_type       pending_pixels [$];

   // Run bookkeeping
   bit                  no_gaps;
   int                  faults;
   int                  idle_cycles;
   int                  loads_taken;
   int                  emits_taken;
   int                  requests_dropped;
   int                  pixels_seen;
   int                  csr_writes;
   int                  useful_items;

   minmax_normalize_to_gray_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_sample     (req_sample),
      .rsp_strobe     (rsp_strobe),
      .rsp_gray       (rsp_gray),
      .rsp_last_pixel (rsp_last_pixel),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int cells_for(logic [CSR_BITS-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > GRID_CELLS_DEF) return GRID_CELLS_DEF;
      return int'(v);
   endfunction

   function automatic void open_frame();
      low_mark     = 32'sh7FFF_FFFF;
      high_mark    = 32'sh8000_0000;
      cells_loaded = 0;
      read_slot    = 0;
      frame_full   = 1'b0;
   endfunction

   // Advance the shadow state for one accepted request; queue the pixel it yields.
   function automatic void predict_pixel(op_type op, logic signed [31:0] sample);
      int                 cells;
      logic signed [31:0] stored;
      longint             span;
      longint             offset;
      gray_type           level;
      logic               last;
      cells = cells_for(cells_setting);
      if (op == OP_LOAD) begin
         if (frame_full) begin
            requests_dropped++;
            return;
         end
         shadow_cells[cells_loaded] = sample;
         if (sample < low_mark) low_mark = sample;
         if (sample > high_mark) high_mark = sample;
         cells_loaded++;
         if (cells_loaded > max_loaded) max_loaded = cells_loaded;
         if (cells_loaded >= cells) frame_full = 1'b1;
         loads_taken++;
         useful_items++;
         return;
      end
      if (!frame_full) begin
         requests_dropped++;
         return;
      end
      stored = shadow_cells[read_slot];
      if (high_mark <= low_mark) begin
         level = '0;
      end else begin
         span = longint'(high_mark) - longint'(low_mark);
         if (stored <= low_mark)       offset = 0;
         else if (stored >= high_mark) offset = span;
         else                          offset = longint'(stored) - longint'(low_mark);
         level = gray_type'((offset * 255) / span);
      end
      last = (read_slot + 1) >= cells;
      pending_pixels.push_back('{level, last});
      if (last) open_frame();
      else read_slot++;
      emits_taken++;
      useful_items++;
   endfunction

   // Present one request after a random gap and hold it until accepted.
   // Start stays high across back-to-back requests so it is never dropped
   // and raised in the same step.
   task automatic send_request(op_type op, logic [31:0] sample);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_op     <= op;
      req_sample <= sample;
      do @(posedge clock); while (busy);
      predict_pixel(op, sample);
   endtask

   // Drop start, wait for every pixel owed, then let a dropped emit finish.
   task automatic settle();
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_cells(logic [CSR_BITS-1:0] v);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cells_setting = v;
      csr_writes++;
   endtask

   function automatic logic [31:0] pick_sample(spread_type spread, logic [31:0] base);
      case (spread)
         SPREAD_WIDE:   return $urandom;
         SPREAD_NARROW: return base + $urandom_range(0, 15);
         SPREAD_FLAT:   return base;
         default: begin
            case ($urandom_range(0, 3))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   // Mostly follow the frame (load until full, then emit), with a few
   // out-of-order requests the unit must drop.
   task automatic walk_frame(spread_type spread, logic [31:0] base);
      op_type op;
      bit     stray;
      stray = ($urandom_range(0, 19) == 0);
      if (frame_full) op = stray ? OP_LOAD : OP_EMIT;
      else            op = stray ? OP_EMIT : OP_LOAD;
      send_request(op, pick_sample(spread, base));
   endtask

   task automatic note_fault(string what, pixel_rec_type want);
      faults++;
      if (faults <= MAX_REPORTS)
         $display("[%0t] %s: expected gray=%0d last=%0b, got gray=%0d last=%0b",
                  $realtime, what, want.gray, want.last, rsp_gray, rsp_last_pixel);
   endtask

   // Check every pixel against the oldest one owed.
   always @(posedge clock) begin : pixel_check
      pixel_rec_type want;
      if (!reset && rsp_strobe) begin
         pixels_seen++;
         if (pending_pixels.size() == 0) begin
            note_fault("pixel with none owed", '{8'd0, 1'b0});
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_gray !== want.gray || rsp_last_pixel !== want.last)
               note_fault("pixel mismatch", want);
         end
      end
   end

   // Count cycles with no handshake of any kind; give up past the limit.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles, %0d pixels owed",
                  IDLE_LIMIT, pending_pixels.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [CSR_BITS-1:0] next_cells;
      spread_type          spread;
      logic [31:0]         base;
      int                  steps;
      bit                  fits;

      cells_setting = CSR_RESET;
      max_loaded    = 0;
      open_frame();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table: pinned rows carry their pixel, the rest use the predictor
      for (int i = 0; i < PLAN_LEN; i++) begin
         no_gaps = (i >= 7 && i <= 11);
         if (PLAN[i].kind == ROW_CSR) begin
            write_cells(PLAN[i].value[CSR_BITS-1:0]);
         end else begin
            send_request(op_type'(PLAN[i].kind == ROW_EMIT ? OP_EMIT : OP_LOAD),
                         PLAN[i].value);
            if (PLAN[i].pinned)
               pending_pixels[pending_pixels.size()-1] = '{PLAN[i].gray, PLAN[i].last};
         end
      end

      // Random phases of small frames; a phase may stop mid-frame and the next
      // may retune the cell count, as long as no unwritten cell would be read
      useful_items = 0;
      while (useful_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 9))
               0:       next_cells = '0;
               1:       next_cells = CSR_BITS'($urandom_range(17, 64));
               default: next_cells = CSR_BITS'($urandom_range(1, 16));
            endcase
            fits = !frame_full || cells_for(next_cells) <= max_loaded;
            if (fits) write_cells(next_cells);
         end
         no_gaps = ($urandom_range(0, 3) == 0);
         spread  = spread_type'($urandom_range(0, 3));
         base    = $urandom;
         steps   = $urandom_range(1, 2 * cells_for(cells_setting) + 4);
         repeat (steps) walk_frame(spread, base);
      end

      // A count above the store size acts as a full-size frame: finish the
      // open frame, then a few loads leave the big frame open and an emit drops
      no_gaps = 1'b0;
      while (frame_full || cells_loaded != 0) walk_frame(SPREAD_WIDE, 32'h0);
      write_cells({CSR_BITS{1'b1}});
      repeat (8) send_request(OP_LOAD, $urandom);
      send_request(OP_EMIT, 32'h0);

      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);

      $display("Covered %0d loads, %0d emits, %0d dropped requests, %0d cell-count writes",
               loads_taken, emits_taken, requests_dropped, csr_writes);
      $display("Checked %0d pixels, %0d mismatches", pixels_seen, faults);
      if (faults == 0 && pending_pixels.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/mmgray_pkg.sv
rtl/core/mmgray_div.sv
rtl/core/minmax_normalize_to_gray_unit.sv
test/testbench.sv
